[src/sce_pkg.sv]
// Package for the shift chain I/O expander: payload types, action codes, constants.
`default_nettype none
package sce_pkg;

    localparam int DATA_W        = 8;
    localparam int CFG_W         = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int MAX_PORTS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 1'd1;

    localparam logic [CFG_W-1:0] COUNT_RESET = 5'd1;

    typedef enum logic [2:0] {
        ACT_WR_OUT_BYTE = 3'd0,
        ACT_RD_OUT_BYTE = 3'd1,
        ACT_RD_IN_BYTE  = 3'd2,
        ACT_WR_OUT_BIT  = 3'd3,
        ACT_RD_OUT_BIT  = 3'd4,
        ACT_RD_IN_BIT   = 3'd5,
        ACT_SHIFT       = 3'd6
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [3:0]        port_address;
        logic [6:0]        bit_address;
        logic [DATA_W-1:0] write_value;
        logic              serial_in;
    } item_t;

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] read_data;
        logic              serial_out;
        logic              latch_pulse;
    } result_t;

    typedef struct packed {
        logic       err;
        logic       latch;
        logic       empty_frame;
        logic [2:0] bit_sel;
    } req_t;

endpackage
`default_nettype wire

[src/shift_chain_io_expander.sv]
// Top level of the shift chain I/O expander: control, image memories and result register.
//
// Usage:
//   item / item_valid / item_ready carry one access or one shift bit per transaction.
//   result / result_valid / result_ready return exactly one result per item.
//   cfg_we / cfg_index / cfg_data set the input and output port counts; a count write
//   clears both byte images and the frame bit position. Write only while idle.
// Timing:
//   The edge that accepts an item issues the image memory reads. In the execute state that
//   follows, the read-modify-write completes and the result is loaded into the output
//   register, unless a pending result holds it. item_ready is low in the execute state,
//   so an item is not taken before the last one is loaded, as the image reads are registered.
//   The next item is accepted while a result still waits in the output register.
// Stall:
//   If the receiver holds result_ready low with a result pending, the item in flight
//   waits with its read data held and item_ready stays low until the register frees.
// Reset:
//   rst_n is asynchronous, active low. Both counts return to 1 and both images read as
//   zero through per-entry valid bits cleared at once; no clearing pass is needed.
`default_nettype none
module shift_chain_io_expander #(
    parameter int MAX_PORTS = sce_pkg::MAX_PORTS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sce_pkg::item_t               item,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    output sce_pkg::result_t                  result,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    input  wire logic                         cfg_we,
    input  wire logic [sce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sce_pkg::CFG_W-1:0]    cfg_data
);

    localparam int AW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int DW = sce_pkg::DATA_W;

    sce_pkg::state_t  state_reg;
    sce_pkg::state_t  state_next;
    sce_pkg::item_t   item_reg;
    sce_pkg::req_t    req;
    sce_pkg::req_t    req_reg;
    sce_pkg::result_t result_reg;
    sce_pkg::result_t result_next;

    logic [sce_pkg::CFG_W-1:0] in_cnt_reg;
    logic [sce_pkg::CFG_W-1:0] out_cnt_reg;
    logic [MAX_PORTS-1:0]      out_vld_reg;
    logic [MAX_PORTS-1:0]      out_vld_next;
    logic [MAX_PORTS-1:0]      in_vld_reg;
    logic [MAX_PORTS-1:0]      in_vld_next;
    logic [AW-1:0]             out_addr;
    logic [AW-1:0]             in_addr;
    logic [AW-1:0]             out_addr_reg;
    logic [AW-1:0]             in_addr_reg;
    logic [DW-1:0]             out_ram_q;
    logic [DW-1:0]             in_ram_q;
    logic [DW-1:0]             out_q;
    logic [DW-1:0]             in_q;
    logic [DW-1:0]             mask;
    logic [DW-1:0]             out_wd;
    logic [DW-1:0]             in_wd;
    logic                      out_we;
    logic                      in_we;
    logic                      accept;
    logic                      out_load;
    logic                      result_valid_reg;
    logic                      result_valid_next;

    assign accept = item_valid && item_ready;

    sce_decode #(
        .MAX_PORTS (MAX_PORTS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .accept    (accept),
        .cfg_clear (cfg_we),
        .in_count  (in_cnt_reg),
        .out_count (out_cnt_reg),
        .out_addr  (out_addr),
        .in_addr   (in_addr),
        .req       (req)
    );

    sce_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_PORTS)
    ) u_out_image (
        .clk   (clk),
        .we    (out_we),
        .waddr (out_addr_reg),
        .wdata (out_wd),
        .re    (accept),
        .raddr (out_addr),
        .rdata (out_ram_q)
    );

    sce_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_PORTS)
    ) u_in_image (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_addr_reg),
        .wdata (in_wd),
        .re    (accept),
        .raddr (in_addr),
        .rdata (in_ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sce_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            sce_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    state_next = sce_pkg::ST_EXEC;
                end
            end
            sce_pkg::ST_EXEC:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = sce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sce_pkg::ST_IDLE;
            end
        endcase
    end

    // execute stage: read-modify-write of the images
    always_comb
    begin
        out_q       = out_vld_reg[out_addr_reg] ? out_ram_q : '0;
        in_q        = in_vld_reg[in_addr_reg] ? in_ram_q : '0;
        mask        = DW'(1) << req_reg.bit_sel;
        out_wd      = '0;
        in_wd       = '0;
        out_we      = 1'b0;
        in_we       = 1'b0;
        result_next = '0;

        unique case (item_reg.action) inside
            sce_pkg::ACT_WR_OUT_BYTE:
            begin
                out_wd                = item_reg.write_value;
                out_we                = out_load && !req_reg.err;
                result_next.read_data = item_reg.write_value;
            end
            sce_pkg::ACT_RD_OUT_BYTE:
            begin
                result_next.read_data = out_q;
            end
            sce_pkg::ACT_RD_IN_BYTE:
            begin
                result_next.read_data = in_q;
            end
            sce_pkg::ACT_WR_OUT_BIT:
            begin
                out_wd                = item_reg.write_value[0] ? (out_q | mask)
                                                                : (out_q & ~mask);
                out_we                = out_load && !req_reg.err;
                result_next.read_data = DW'(item_reg.write_value[0]);
            end
            sce_pkg::ACT_RD_OUT_BIT:
            begin
                result_next.read_data = DW'(out_q[req_reg.bit_sel]);
            end
            sce_pkg::ACT_RD_IN_BIT:
            begin
                result_next.read_data = DW'(in_q[req_reg.bit_sel]);
            end
            sce_pkg::ACT_SHIFT:
            begin
                in_wd                   = item_reg.serial_in ? (in_q | mask) : (in_q & ~mask);
                in_we                   = out_load && !req_reg.empty_frame;
                result_next.serial_out  = !req_reg.empty_frame && out_q[req_reg.bit_sel];
                result_next.latch_pulse = req_reg.latch;
            end
            default:
            begin
                result_next = '0;
            end
        endcase

        if (req_reg.err)
        begin
            result_next        = '0;
            result_next.status = 1'b1;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        in_vld_next  = in_vld_reg;
        if (cfg_we)
        begin
            out_vld_next = '0;
            in_vld_next  = '0;
        end
        else
        begin
            if (out_we)
            begin
                out_vld_next[out_addr_reg] = 1'b1;
            end
            if (in_we)
            begin
                in_vld_next[in_addr_reg] = 1'b1;
            end
        end

        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg       <= sce_pkg::COUNT_RESET;
            out_cnt_reg      <= sce_pkg::COUNT_RESET;
            out_vld_reg      <= '0;
            in_vld_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg      <= out_vld_next;
            in_vld_reg       <= in_vld_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sce_pkg::CFG_IN_COUNT:  in_cnt_reg  <= cfg_data;
                    sce_pkg::CFG_OUT_COUNT: out_cnt_reg <= cfg_data;
                    default:                in_cnt_reg  <= in_cnt_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= item;
            req_reg      <= req;
            out_addr_reg <= out_addr;
            in_addr_reg  <= in_addr;
        end
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("item accepted while previous item still executing");

    a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.status && (result.read_data != '0)))
        else $error("error status with nonzero read data");

    a_latch_on_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (result_next.latch_pulse || result_next.serial_out))
        |-> (item_reg.action == sce_pkg::ACT_SHIFT))
        else $error("latch or serial data on a non-shift transaction");

endmodule
`default_nettype wire

[src/sce_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[src/sce_decode.sv]
// Item decode: range checks, frame address mapping and the frame bit position counter.
`default_nettype none
module sce_decode #(
    parameter int MAX_PORTS = sce_pkg::MAX_PORTS_DEF,
    localparam int AW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sce_pkg::item_t           item,
    input  wire logic                     accept,
    input  wire logic                     cfg_clear,
    input  wire logic [sce_pkg::CFG_W-1:0] in_count,
    input  wire logic [sce_pkg::CFG_W-1:0] out_count,
    output logic      [AW-1:0]            out_addr,
    output logic      [AW-1:0]            in_addr,
    output sce_pkg::req_t                 req
);

    localparam int CNT_W = $clog2(MAX_PORTS + 1);
    localparam int EW    = (CNT_W > sce_pkg::CFG_W) ? CNT_W : sce_pkg::CFG_W;
    localparam int TW    = EW + 3;
    localparam int POS_W = AW + 3;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    logic [EW-1:0] in_ext;
    logic [EW-1:0] out_ext;
    logic [EW-1:0] in_cnt;
    logic [EW-1:0] out_cnt;
    logic [EW-1:0] flen;
    logic [EW-1:0] sel_ext;
    logic [EW-1:0] out_diff;
    logic [TW-1:0] total;
    logic [TW-1:0] pos_ext;
    logic [TW-1:0] pos_eff;
    logic [TW-1:0] pos_inc;
    logic [3:0]    sel;
    logic          is_byte;
    logic          is_shift;
    logic          out_ok;
    logic          in_ok;
    logic          wrap;
    logic          empty;

    always_comb
    begin
        in_ext   = EW'(in_count);
        out_ext  = EW'(out_count);
        in_cnt   = (in_ext > EW'(MAX_PORTS)) ? EW'(MAX_PORTS) : in_ext;
        out_cnt  = (out_ext > EW'(MAX_PORTS)) ? EW'(MAX_PORTS) : out_ext;
        flen     = (in_cnt >= out_cnt) ? in_cnt : out_cnt;
        is_shift = (item.action == sce_pkg::ACT_SHIFT);
        is_byte  = (item.action == sce_pkg::ACT_WR_OUT_BYTE) ||
                   (item.action == sce_pkg::ACT_RD_OUT_BYTE) ||
                   (item.action == sce_pkg::ACT_RD_IN_BYTE);
        sel      = is_byte ? item.port_address : item.bit_address[6:3];
        sel_ext  = EW'(sel);
        out_ok   = (sel_ext < out_cnt);
        in_ok    = (sel_ext < in_cnt);
        out_diff = flen - EW'(1) - sel_ext;

        total    = {flen, 3'b000};
        pos_ext  = TW'(pos_reg);
        pos_eff  = (pos_ext >= total) ? '0 : pos_ext;
        pos_inc  = pos_eff + TW'(1);
        wrap     = (pos_inc >= total);
        empty    = (flen == '0);

        out_addr = is_shift ? AW'(pos_eff >> 3) : out_diff[AW-1:0];
        in_addr  = is_shift ? AW'(pos_eff >> 3) : sel_ext[AW-1:0];

        req.bit_sel     = is_shift ? ~pos_eff[2:0] : item.bit_address[2:0];
        req.empty_frame = empty;
        req.latch       = is_shift && (empty || wrap);

        unique case (item.action) inside
            sce_pkg::ACT_WR_OUT_BYTE, sce_pkg::ACT_RD_OUT_BYTE,
            sce_pkg::ACT_WR_OUT_BIT, sce_pkg::ACT_RD_OUT_BIT:
                req.err = !out_ok;
            sce_pkg::ACT_RD_IN_BYTE, sce_pkg::ACT_RD_IN_BIT:
                req.err = !in_ok;
            sce_pkg::ACT_SHIFT:
                req.err = 1'b0;
            default:
                req.err = 1'b1;
        endcase

        pos_next = pos_reg;
        if (cfg_clear)
        begin
            pos_next = '0;
        end
        else if (accept && is_shift)
        begin
            pos_next = (empty || wrap) ? '0 : POS_W'(pos_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule
`default_nettype wire

[bench/shift_chain_io_expander_tb.sv]
`timescale 1ns / 1ps
// Testbench for the shift chain I/O expander: directed and random transactions scored by a predictor.
module shift_chain_io_expander_tb;
    import sce_pkg::*;

    localparam int         PORTS        = MAX_PORTS_DEF;
    localparam logic [2:0] ACT_UNUSED   = 3'd7;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         RANDOM_ITEMS = 1450;
    localparam int         CALM_TAIL    = 200;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    item_t                item         = '0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    result_t              result;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_IN_COUNT;
    logic [CFG_W-1:0]     cfg_data     = '0;

    shift_chain_io_expander dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    logic [7:0]       out_image [PORTS];
    logic [7:0]       in_image  [PORTS];
    int unsigned      frame_pos;
    logic [CFG_W-1:0] in_count_reg  = COUNT_RESET;
    logic [CFG_W-1:0] out_count_reg = COUNT_RESET;

    item_t   send_q [$];
    result_t expected_q [$];
    result_t due_result;
    int      errors     = 0;
    bit      gaps_on    = 1'b1;
    int      send_gap   = 0;
    int      recv_stall = 0;
    int      quiet      = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned port_limit(logic [CFG_W-1:0] c);
        return (c > PORTS) ? PORTS : int'(c);
    endfunction

    function automatic int unsigned frame_bytes();
        int unsigned a;
        int unsigned b;
        a = port_limit(in_count_reg);
        b = port_limit(out_count_reg);
        return (a >= b) ? a : b;
    endfunction

    function automatic void clear_images();
        for (int i = 0; i < PORTS; i++)
        begin
            out_image[i] = '0;
            in_image[i]  = '0;
        end
        frame_pos = 0;
    endfunction

    function automatic result_t expander_step(item_t it);
        result_t     r;
        int unsigned n_in;
        int unsigned n_out;
        int unsigned flen;
        int unsigned bsel;
        int unsigned total;
        int unsigned fb;
        logic [7:0]  m;
        r     = '0;
        n_in  = port_limit(in_count_reg);
        n_out = port_limit(out_count_reg);
        flen  = frame_bytes();
        bsel  = it.bit_address >> 3;
        m     = 8'h01 << it.bit_address[2:0];
        case (it.action)
            ACT_WR_OUT_BYTE:
                if (it.port_address < n_out)
                begin
                    out_image[flen - 1 - it.port_address] = it.write_value;
                    r.read_data = it.write_value;
                end
                else
                    r.status = 1'b1;
            ACT_RD_OUT_BYTE:
                if (it.port_address < n_out)
                    r.read_data = out_image[flen - 1 - it.port_address];
                else
                    r.status = 1'b1;
            ACT_RD_IN_BYTE:
                if (it.port_address < n_in)
                    r.read_data = in_image[it.port_address];
                else
                    r.status = 1'b1;
            ACT_WR_OUT_BIT:
                if (bsel < n_out)
                begin
                    if (it.write_value[0])
                        out_image[flen - 1 - bsel] = out_image[flen - 1 - bsel] | m;
                    else
                        out_image[flen - 1 - bsel] = out_image[flen - 1 - bsel] & ~m;
                    r.read_data = {7'b0, it.write_value[0]};
                end
                else
                    r.status = 1'b1;
            ACT_RD_OUT_BIT:
                if (bsel < n_out)
                    r.read_data = {7'b0, |(out_image[flen - 1 - bsel] & m)};
                else
                    r.status = 1'b1;
            ACT_RD_IN_BIT:
                if (bsel < n_in)
                    r.read_data = {7'b0, |(in_image[bsel] & m)};
                else
                    r.status = 1'b1;
            ACT_SHIFT:
            begin
                total = flen * 8;
                if (total == 0)
                begin
                    r.latch_pulse = 1'b1;
                    frame_pos     = 0;
                end
                else
                begin
                    if (frame_pos >= total)
                        frame_pos = 0;
                    fb = frame_pos >> 3;
                    m  = 8'h80 >> (frame_pos % 8);
                    r.serial_out = |(out_image[fb] & m);
                    if (it.serial_in)
                        in_image[fb] = in_image[fb] | m;
                    else
                        in_image[fb] = in_image[fb] & ~m;
                    frame_pos++;
                    if (frame_pos >= total)
                    begin
                        frame_pos     = 0;
                        r.latch_pulse = 1'b1;
                    end
                end
            end
            default:
                r.status = 1'b1;
        endcase
        return r;
    endfunction

    function automatic item_t random_item(int shift_pct);
        item_t       it;
        int unsigned span;
        int unsigned bit_top;
        span    = frame_bytes();
        bit_top = (span * 8 + 7 > 127) ? 127 : span * 8 + 7;
        it.action = ACT_SHIFT;
        if ($urandom_range(0, 99) >= shift_pct)
        begin
            if ($urandom_range(0, 40) == 0)
                it.action = ACT_UNUSED;
            else
                it.action = 3'($urandom_range(ACT_WR_OUT_BYTE, ACT_RD_IN_BIT));
        end
        if ($urandom_range(0, 4) == 0)
            it.port_address = 4'($urandom_range(0, 15));
        else
            it.port_address = 4'($urandom_range(0, (span > 15) ? 15 : span));
        if ($urandom_range(0, 4) == 0)
            it.bit_address = 7'($urandom_range(0, 127));
        else
            it.bit_address = 7'($urandom_range(0, bit_top));
        it.write_value = 8'($urandom_range(0, 255));
        it.serial_in   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic push_item(logic [2:0] act, logic [3:0] port, logic [6:0] baddr,
                             logic [7:0] wval, logic sin);
        item_t it;
        it.action       = act;
        it.port_address = port;
        it.bit_address  = baddr;
        it.write_value  = wval;
        it.serial_in    = sin;
        send_q.push_back(it);
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    task automatic wait_drain();
        while (send_q.size() != 0 || item_valid || expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_counts(logic [CFG_W-1:0] n_in, logic [CFG_W-1:0] n_out);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IN_COUNT;
        cfg_data  <= n_in;
        @(posedge clk);
        cfg_index <= CFG_OUT_COUNT;
        cfg_data  <= n_out;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        in_count_reg  = n_in;
        out_count_reg = n_out;
        clear_images();
    endtask

    // driver: predicts each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                expected_q.push_back(expander_step(item));
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (send_q.size() > 0)
                begin
                    item       <= send_q.pop_front();
                    item_valid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 15);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result", result.read_data, 8'h00);
                else
                begin
                    due_result = expected_q.pop_front();
                    if (result.status !== due_result.status)
                        report_mismatch("status", result.status, due_result.status);
                    if (result.read_data !== due_result.read_data)
                        report_mismatch("read_data", result.read_data, due_result.read_data);
                    if (result.serial_out !== due_result.serial_out)
                        report_mismatch("serial_out", result.serial_out, due_result.serial_out);
                    if (result.latch_pulse !== due_result.latch_pulse)
                        report_mismatch("latch_pulse", result.latch_pulse,
                                        due_result.latch_pulse);
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 9) == 0)
                    recv_stall = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        int n_rand;
        int ph;
        int n_in;
        int n_out;
        int n_items;
        int shift_pct;
        clear_images();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset counts: one input byte, one output byte
        push_item(ACT_WR_OUT_BYTE, 4'd0, 7'd0, 8'hFF, 1'b0);
        push_item(ACT_WR_OUT_BYTE, 4'd15, 7'd0, 8'h5A, 1'b0);
        push_item(ACT_RD_OUT_BYTE, 4'd0, 7'd0, 8'h00, 1'b0);
        push_item(ACT_RD_IN_BYTE, 4'd0, 7'd0, 8'h00, 1'b0);
        push_item(ACT_RD_IN_BYTE, 4'd1, 7'd0, 8'h00, 1'b0);
        push_item(ACT_WR_OUT_BIT, 4'd0, 7'd0, 8'h00, 1'b0);
        push_item(ACT_WR_OUT_BIT, 4'd0, 7'd7, 8'hFE, 1'b0);
        push_item(ACT_WR_OUT_BIT, 4'd0, 7'd127, 8'h01, 1'b0);
        push_item(ACT_RD_OUT_BIT, 4'd0, 7'd0, 8'h00, 1'b0);
        push_item(ACT_RD_OUT_BIT, 4'd0, 7'd1, 8'h00, 1'b0);
        push_item(ACT_RD_IN_BIT, 4'd0, 7'd3, 8'h00, 1'b0);
        push_item(ACT_RD_IN_BIT, 4'd0, 7'd8, 8'h00, 1'b0);
        push_item(ACT_UNUSED, 4'd15, 7'd127, 8'hFF, 1'b1);
        for (int i = 0; i < 8; i++)
            push_item(ACT_SHIFT, 4'd0, 7'd0, 8'h00, 1'(i));
        push_item(ACT_RD_IN_BYTE, 4'd0, 7'd0, 8'h00, 1'b0);
        push_item(ACT_RD_IN_BIT, 4'd0, 7'd0, 8'h00, 1'b0);

        // empty frame
        set_counts(5'd0, 5'd0);
        push_item(ACT_SHIFT, 4'd0, 7'd0, 8'h00, 1'b1);
        push_item(ACT_RD_OUT_BYTE, 4'd0, 7'd0, 8'h00, 1'b0);

        // counts above the port limit
        set_counts(5'd31, 5'd31);
        push_item(ACT_WR_OUT_BYTE, 4'd15, 7'd0, 8'h81, 1'b0);
        push_item(ACT_RD_OUT_BIT, 4'd0, 7'd120, 8'h00, 1'b0);
        push_item(ACT_SHIFT, 4'd0, 7'd0, 8'h00, 1'b1);
        push_item(ACT_RD_IN_BIT, 4'd0, 7'd7, 8'h00, 1'b0);

        n_rand = 0;
        ph     = 0;
        while (n_rand < RANDOM_ITEMS)
        begin
            case (ph % 8)
                0:
                begin
                    n_in  = 16;
                    n_out = 16;
                end
                1:
                begin
                    n_in  = 31;
                    n_out = $urandom_range(0, 31);
                end
                2:
                begin
                    n_in  = 0;
                    n_out = $urandom_range(1, 3);
                end
                3:
                begin
                    n_in  = $urandom_range(1, 3);
                    n_out = 0;
                end
                default:
                begin
                    n_in  = $urandom_range(0, 4);
                    n_out = $urandom_range(0, 4);
                end
            endcase
            gaps_on = (n_rand < RANDOM_ITEMS - CALM_TAIL);
            set_counts(5'(n_in), 5'(n_out));
            n_items   = (frame_bytes() > 4) ? 220 : 60;
            shift_pct = (frame_bytes() > 4) ? 70 : 40;
            for (int i = 0; i < n_items; i++)
                send_q.push_back(random_item(shift_pct));
            n_rand += n_items;
            ph++;
        end

        wait_drain();
        repeat (10) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("results never returned", 8'(expected_q.size()), 8'h00);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
